### src/buddy_page_allocator_macros.svh
// Assertion macros for the buddy page allocator.
`ifndef BUDDY_PAGE_ALLOCATOR_MACROS_SVH
`define BUDDY_PAGE_ALLOCATOR_MACROS_SVH
`ifndef SYNTH
`define BPA_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("buddy allocator check failed");
`define BPA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("buddy allocator check failed");
`else
`define BPA_ASSERT_NOW(label, ante, cons)
`define BPA_ASSERT_NEXT(label, ante, cons)
`endif
`endif

### src/bpa_pkg.sv
// Types and constants shared by the buddy page allocator modules.
package bpa_pkg;

  localparam int PAGE_W    = 12;
  localparam int NUM_PAGES = 4096;
  localparam int LINK_W    = 13;
  localparam int CNT_W     = 13;
  localparam int ORD_W     = 4;

  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_ORDER = 2'd1,
    ST_NOMEM = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_ASCAN,
    S_APOP,
    S_PUSH,
    S_PUSH2,
    S_FTOG,
    S_FCHK,
    S_FUNL,
    S_DONE
  } state_t;

  typedef struct packed {
    logic              action;
    logic [PAGE_W-1:0] page;
    logic [ORD_W-1:0]  order;
    logic              dma;
  } in_word_t;

  typedef struct packed {
    logic              ok;
    logic [PAGE_W-1:0] block_page;
    logic [1:0]        status;
    logic [CNT_W-1:0]  free_count;
  } out_word_t;

  typedef struct packed {
    logic              we;
    logic [PAGE_W-1:0] waddr;
    logic [LINK_W-1:0] wdata;
    logic              re;
    logic [PAGE_W-1:0] raddr;
  } link_port_t;

endpackage

### src/buddy_page_allocator.sv
// Top level of the buddy page allocator: sequencer, list heads and result register.
//
//   channel | direction | handshake         | word
//   in      | input     | in_valid/in_stall   | bpa_pkg::in_word_t
//   out     | output    | out_valid/out_stall | bpa_pkg::out_word_t
//   cfg     | input     | cfg_we              | page_limit (13 bits)
//
// Allocate: accept, scan the orders in each pool, pop, split down order by order, finish.
// Free: accept, per merge toggle/check/unlink, toggle/check if no free buddy, push, finish.
// Order and range errors skip to finish. Every step shares one link RAM port pair and the bitmap port.
// After reset all NUM_POOLS * 4096 bitmap bits are swept while in_stall stays high.
// A finished word waits in the output register; a stalled output holds the last step.
module buddy_page_allocator #(
  parameter int NUM_ORDERS = 10,
  parameter int NUM_POOLS  = 2
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  bpa_pkg::in_word_t         in_word,
  output logic                      out_valid,
  input  logic                      out_stall,
  output bpa_pkg::out_word_t        out_word,
  input  logic                      cfg_we,
  input  logic [bpa_pkg::CNT_W-1:0] cfg_wdata
);
  import bpa_pkg::*;

  `include "buddy_page_allocator_macros.svh"

  localparam int NL  = NUM_POOLS * NUM_ORDERS;
  localparam int LSW = $clog2(NL);
  localparam int BMD = NUM_POOLS * NUM_PAGES;
  localparam int BMW = $clog2(BMD);
  localparam logic [LINK_W-1:0] NIL = LINK_W'(NUM_PAGES);

  function automatic logic [LSW-1:0] list_idx(input logic pool, input logic [ORD_W-1:0] o);
    int v;
    v = (pool && NUM_POOLS > 1) ? NUM_ORDERS + int'(o) : int'(o);
    return LSW'(v);
  endfunction

  function automatic logic [BMW-1:0] bm_index(input logic pool, input logic [ORD_W-1:0] o,
                                              input logic [PAGE_W-1:0] p);
    logic [PAGE_W:0]   base;
    logic [PAGE_W-1:0] sh;
    logic [BMW-1:0]    idx;
    base = (PAGE_W+1)'(NUM_PAGES) - ((PAGE_W+1)'(NUM_PAGES) >> o);
    sh   = p >> (o + ORD_W'(1));
    idx  = BMW'(base) + BMW'(sh);
    if (pool && NUM_POOLS > 1) begin
      idx = idx + BMW'(NUM_PAGES);
    end
    return idx;
  endfunction

  function automatic logic [PAGE_W-1:0] align(input logic [PAGE_W-1:0] p,
                                              input logic [ORD_W-1:0] o);
    logic [PAGE_W-1:0] m;
    m = (PAGE_W'(1) << o) - PAGE_W'(1);
    return p & ~m;
  endfunction

  function automatic logic [LINK_W-1:0] head_mark(input logic [LSW-1:0] l);
    return NIL + LINK_W'(l);
  endfunction

  state_t            state_r, state_nxt;
  logic              act_r, act_nxt;
  logic              pool_r, pool_nxt;
  logic              both_r, both_nxt;
  logic [ORD_W-1:0]  req_r, req_nxt;
  logic [ORD_W-1:0]  o_r, o_nxt;
  logic [PAGE_W-1:0] p_r, p_nxt;
  logic [LINK_W-1:0] nx_r, nx_nxt;
  logic [CNT_W-1:0]  fp_r, fp_nxt;
  status_t           stat_r, stat_nxt;
  logic [PAGE_W-1:0] blk_r, blk_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_word_t         out_word_r, out_word_nxt;
  logic [CNT_W-1:0]  page_limit_r;
  logic [LINK_W-1:0] heads_r [NL];

  logic              heads_we;
  logic [LSW-1:0]    heads_wa;
  logic [LINK_W-1:0] heads_wd;

  link_port_t        nport, pport;
  logic [LINK_W-1:0] next_rdata, prev_rdata;
  logic              bm_re, bm_we, bm_wdata, bm_rdata, bm_busy;
  logic [BMW-1:0]    bm_raddr, bm_waddr;

  logic              accept, out_free, in_bad_order, in_bad_page;
  logic [LSW-1:0]    cur_l;
  logic [LINK_W-1:0] cur_head;
  logic              o_top, o_last, merge_more, in_merge;

  bpa_ram u_next (.clk(clk), .port(nport), .rdata(next_rdata));
  bpa_ram u_prev (.clk(clk), .port(pport), .rdata(prev_rdata));

  bpa_bitmap #(.DEPTH(BMD)) u_bitmap (
    .clk(clk), .rst_n(rst_n),
    .re(bm_re), .raddr(bm_raddr), .we(bm_we), .waddr(bm_waddr), .wdata(bm_wdata),
    .rdata(bm_rdata), .busy(bm_busy)
  );

  assign accept       = in_valid && !in_stall;
  assign out_free     = !out_valid_r || !out_stall;
  assign in_bad_order = int'(in_word.order) >= NUM_ORDERS;
  assign in_bad_page  = {1'b0, in_word.page} >= page_limit_r;
  assign in_merge     = int'(in_word.order) + 1 < NUM_ORDERS;
  assign cur_l        = list_idx(pool_r, o_r);
  assign cur_head     = heads_r[cur_l];
  assign o_top        = int'(o_r) == NUM_ORDERS - 1;
  assign o_last       = o_r == req_r;
  assign merge_more   = int'(o_r) + 2 < NUM_ORDERS;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: if (!bm_busy) state_nxt = S_IDLE;
      S_IDLE: begin
        if (accept) begin
          if (in_bad_order) begin
            state_nxt = S_DONE;
          end else if (in_word.action == ACT_ALLOC) begin
            state_nxt = S_ASCAN;
          end else if (in_bad_page) begin
            state_nxt = S_DONE;
          end else if (in_merge) begin
            state_nxt = S_FTOG;
          end else begin
            state_nxt = S_PUSH;
          end
        end
      end
      S_ASCAN: begin
        if (!cur_head[PAGE_W]) begin
          state_nxt = S_APOP;
        end else if (o_top && !(both_r && !pool_r)) begin
          state_nxt = S_DONE;
        end
      end
      S_APOP:  state_nxt = o_last ? S_DONE : S_PUSH;
      S_PUSH:  state_nxt = S_PUSH2;
      S_PUSH2: state_nxt = (act_r == ACT_FREE || o_last) ? S_DONE : S_PUSH;
      S_FTOG:  state_nxt = S_FCHK;
      S_FCHK:  state_nxt = bm_rdata ? S_FUNL : S_PUSH;
      S_FUNL:  state_nxt = merge_more ? S_FTOG : S_PUSH;
      S_DONE:  if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_CLEAR;
    endcase
  end

  always_comb begin
    logic [LINK_W-1:0] nx;
    logic [LINK_W-1:0] pv;
    logic [PAGE_W-1:0] bud;
    nx            = next_rdata;
    pv            = prev_rdata;
    bud           = p_r ^ (PAGE_W'(1) << o_r);
    act_nxt       = act_r;
    pool_nxt      = pool_r;
    both_nxt      = both_r;
    req_nxt       = req_r;
    o_nxt         = o_r;
    p_nxt         = p_r;
    nx_nxt        = nx_r;
    fp_nxt        = fp_r;
    stat_nxt      = stat_r;
    blk_nxt       = blk_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_word_nxt  = out_word_r;
    heads_we      = 1'b0;
    heads_wa      = cur_l;
    heads_wd      = nx;
    nport         = '{we: 1'b0, waddr: p_r, wdata: nx, re: 1'b0, raddr: p_r};
    pport         = '{we: 1'b0, waddr: p_r, wdata: nx, re: 1'b0, raddr: p_r};
    bm_re         = 1'b0;
    bm_raddr      = bm_index(pool_r, o_r, p_r);
    bm_we         = 1'b0;
    bm_waddr      = bm_index(pool_r, o_r, p_r);
    bm_wdata      = !bm_rdata;
    in_stall      = state_r != S_IDLE;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          act_nxt  = in_word.action;
          pool_nxt = (NUM_POOLS > 1) ? in_word.dma : 1'b0;
          both_nxt = !in_word.dma && NUM_POOLS > 1;
          req_nxt  = in_word.order;
          o_nxt    = in_word.order;
          blk_nxt  = '0;
          stat_nxt = ST_OK;
          if (in_bad_order) begin
            stat_nxt = ST_ORDER;
          end else if (in_word.action == ACT_FREE) begin
            if (in_bad_page) begin
              stat_nxt = ST_RANGE;
            end else begin
              p_nxt  = align(in_word.page, in_word.order);
              fp_nxt = fp_r + (CNT_W'(1) << in_word.order);
            end
          end
        end
      end
      S_ASCAN: begin
        if (!cur_head[PAGE_W]) begin
          p_nxt        = cur_head[PAGE_W-1:0];
          nport.re     = 1'b1;
          nport.raddr  = cur_head[PAGE_W-1:0];
          bm_re        = 1'b1;
          bm_raddr     = bm_index(pool_r, o_r, cur_head[PAGE_W-1:0]);
        end else if (o_top) begin
          if (both_r && !pool_r) begin
            pool_nxt = 1'b1;
            o_nxt    = req_r;
          end else begin
            stat_nxt = ST_NOMEM;
          end
        end else begin
          o_nxt = o_r + ORD_W'(1);
        end
      end
      S_APOP: begin
        heads_we    = 1'b1;
        heads_wd    = nx;
        pport.we    = !nx[PAGE_W];
        pport.waddr = nx[PAGE_W-1:0];
        pport.wdata = head_mark(cur_l);
        bm_we       = 1'b1;
        fp_nxt      = fp_r - (CNT_W'(1) << req_r);
        if (o_last) begin
          blk_nxt = p_r;
        end else begin
          o_nxt = o_r - ORD_W'(1);
        end
      end
      S_PUSH: begin
        nx_nxt      = cur_head;
        nport.we    = 1'b1;
        nport.wdata = cur_head;
        pport.we    = 1'b1;
        pport.wdata = head_mark(cur_l);
        heads_we    = 1'b1;
        heads_wd    = {1'b0, p_r};
        bm_re       = act_r == ACT_ALLOC;
      end
      S_PUSH2: begin
        pport.we    = !nx_r[PAGE_W];
        pport.waddr = nx_r[PAGE_W-1:0];
        pport.wdata = {1'b0, p_r};
        if (act_r == ACT_ALLOC) begin
          bm_we = 1'b1;
          p_nxt = p_r + (PAGE_W'(1) << o_r);
          if (o_last) begin
            blk_nxt = p_r + (PAGE_W'(1) << o_r);
          end else begin
            o_nxt = o_r - ORD_W'(1);
          end
        end
      end
      S_FTOG: begin
        bm_re = 1'b1;
      end
      S_FCHK: begin
        bm_we = 1'b1;
        if (bm_rdata) begin
          nport.re    = 1'b1;
          nport.raddr = bud;
          pport.re    = 1'b1;
          pport.raddr = bud;
        end
      end
      S_FUNL: begin
        pport.we    = !nx[PAGE_W];
        pport.waddr = nx[PAGE_W-1:0];
        pport.wdata = pv;
        nport.we    = !pv[PAGE_W];
        nport.waddr = pv[PAGE_W-1:0];
        nport.wdata = nx;
        heads_we    = pv[PAGE_W] && int'(pv[PAGE_W-1:0]) < NL;
        heads_wa    = LSW'(pv[PAGE_W-1:0]);
        heads_wd    = nx;
        o_nxt       = o_r + ORD_W'(1);
        p_nxt       = align(p_r, o_r + ORD_W'(1));
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt           = 1'b1;
          out_word_nxt.ok         = stat_r == ST_OK;
          out_word_nxt.block_page = blk_r;
          out_word_nxt.status     = stat_r;
          out_word_nxt.free_count = fp_r;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      out_valid_r  <= 1'b0;
      fp_r         <= '0;
      page_limit_r <= CNT_W'(NUM_PAGES);
      for (int i = 0; i < NL; i++) begin
        heads_r[i] <= NIL;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      fp_r        <= fp_nxt;
      if (cfg_we) begin
        page_limit_r <= cfg_wdata;
      end
      if (heads_we) begin
        heads_r[heads_wa] <= heads_wd;
      end
    end
  end

  always_ff @(posedge clk) begin
    act_r      <= act_nxt;
    pool_r     <= pool_nxt;
    both_r     <= both_nxt;
    req_r      <= req_nxt;
    o_r        <= o_nxt;
    p_r        <= p_nxt;
    nx_r       <= nx_nxt;
    stat_r     <= stat_nxt;
    blk_r      <= blk_nxt;
    out_word_r <= out_word_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  `BPA_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)
  `BPA_ASSERT_NOW(a_ok_matches_status, out_valid, out_word.ok == (out_word.status == ST_OK))
  `BPA_ASSERT_NOW(a_scan_order_range, state_r == S_ASCAN, int'(o_r) < NUM_ORDERS)
  `BPA_ASSERT_NOW(a_split_above_req, state_r == S_PUSH2 && act_r == ACT_ALLOC, o_r >= req_r)

endmodule

### src/bpa_ram.sv
// Single-port-write, registered-read RAM for the page link tables.
module bpa_ram (
  input  logic                       clk,
  input  bpa_pkg::link_port_t        port,
  output logic [bpa_pkg::LINK_W-1:0] rdata
);
  import bpa_pkg::*;

  logic [LINK_W-1:0] mem [NUM_PAGES];

  always_ff @(posedge clk) begin
    if (port.we) begin
      mem[port.waddr] <= port.wdata;
    end
    if (port.re) begin
      rdata <= mem[port.raddr];
    end
  end

endmodule

### src/bpa_bitmap.sv
// Pair-toggle bitmap memory with a clearing sweep after reset.
module bpa_bitmap #(
  parameter int DEPTH = 8192
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic                     wdata,
  output logic                     rdata,
  output logic                     busy
);
  localparam int AW = $clog2(DEPTH);

  logic          mem [DEPTH];
  logic [AW-1:0] clr_addr_r;
  logic [AW-1:0] clr_addr_nxt;
  logic          busy_r;
  logic          busy_nxt;

  always_comb begin
    clr_addr_nxt = clr_addr_r;
    busy_nxt     = busy_r;
    if (busy_r) begin
      clr_addr_nxt = clr_addr_r + AW'(1);
      if (clr_addr_r == AW'(DEPTH - 1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r <= '0;
      busy_r     <= 1'b1;
    end else begin
      clr_addr_r <= clr_addr_nxt;
      busy_r     <= busy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (busy_r) begin
      mem[clr_addr_r] <= 1'b0;
    end else if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

  assign busy = busy_r;

endmodule

### tb/sv/testbench.sv
// Self-checking testbench for the buddy page allocator with its own allocator predictor.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import bpa_pkg::*;

  localparam int ORDERS = 10;
  localparam int LISTS  = 2 * ORDERS;
  localparam int NIL    = NUM_PAGES;

  typedef struct {
    in_word_t  w;
    bit        chk;
    out_word_t e;
  } stim_row_t;

  typedef struct {
    int pg;
    int ord;
    int pool;
  } block_t;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  in_word_t in_word;
  logic out_valid;
  logic out_stall;
  out_word_t out_word;
  logic cfg_we;
  logic [CNT_W-1:0] cfg_wdata;

  int unsigned next_pg [NUM_PAGES];
  int unsigned prev_pg [NUM_PAGES];
  int unsigned head_pg [LISTS];
  logic [CNT_W-1:0] list_len [LISTS];
  bit pair_bits [2*NUM_PAGES];
  logic [CNT_W-1:0] pages_free;
  logic [CNT_W-1:0] limit_pages;

  out_word_t pending_results[$];
  block_t held_blocks[$];
  stim_row_t directed_rows[$];
  int mismatches = 0;
  int stall_cnt = 0;
  int stall_mode = 0;

  buddy_page_allocator DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
    .out_valid(out_valid), .out_stall(out_stall), .out_word(out_word),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always #6 clk = ~clk;

  function automatic bit flip_pair(int pool, int o, int p);
    int idx;
    bit old;
    idx = pool * NUM_PAGES + (NUM_PAGES - (NUM_PAGES >> o)) + (p >> (o + 1));
    old = pair_bits[idx];
    pair_bits[idx] = ~old;
    return old;
  endfunction

  function automatic void push_block(int l, int p);
    int nx;
    nx = head_pg[l];
    next_pg[p] = nx;
    prev_pg[p] = NIL + l;
    if (nx < NIL) prev_pg[nx] = p;
    head_pg[l] = p;
    list_len[l] = list_len[l] + 1'b1;
  endfunction

  function automatic void unlink_block(int p);
    int nx;
    int pv;
    nx = next_pg[p];
    pv = prev_pg[p];
    if (nx < NIL) prev_pg[nx] = pv;
    if (pv < NIL) next_pg[pv] = nx;
    else if (pv - NIL < LISTS) head_pg[pv - NIL] = nx;
  endfunction

  function automatic bit take_block(int pool, int order, output int blk);
    int l;
    int p;
    int nx;
    blk = 0;
    for (int o = order; o < ORDERS; o++) begin
      l = pool * ORDERS + o;
      p = head_pg[l];
      if (p >= NIL) continue;
      nx = next_pg[p];
      head_pg[l] = nx;
      if (nx < NIL) prev_pg[nx] = NIL + l;
      void'(flip_pair(pool, o, p));
      pages_free = pages_free - CNT_W'(1 << order);
      list_len[l] = list_len[l] - 1'b1;
      while (o > order) begin
        o--;
        push_block(pool * ORDERS + o, p);
        void'(flip_pair(pool, o, p));
        p += 1 << o;
      end
      blk = p;
      return 1;
    end
    return 0;
  endfunction

  function automatic out_word_t allocator_step(in_word_t w, output int pool_used);
    out_word_t r;
    int blk;
    int o;
    int p;
    bit got;
    status_t st;
    st = ST_OK;
    blk = 0;
    pool_used = w.dma;
    if (w.order >= ORDERS) begin
      st = ST_ORDER;
    end else if (w.action == ACT_ALLOC) begin
      if (w.dma) begin
        got = take_block(1, w.order, blk);
      end else begin
        pool_used = 0;
        got = take_block(0, w.order, blk);
        if (!got) begin
          pool_used = 1;
          got = take_block(1, w.order, blk);
        end
      end
      if (!got) begin
        st = ST_NOMEM;
        blk = 0;
      end
    end else if (w.page >= limit_pages) begin
      st = ST_RANGE;
    end else begin
      o = w.order;
      p = w.page & ~((1 << o) - 1);
      pages_free = pages_free + CNT_W'(1 << w.order);
      while (o + 1 < ORDERS) begin
        if (!flip_pair(w.dma, o, p)) break;
        list_len[w.dma * ORDERS + o] = list_len[w.dma * ORDERS + o] - 1'b1;
        unlink_block(p ^ (1 << o));
        o++;
        p &= ~((1 << o) - 1);
      end
      push_block(w.dma * ORDERS + o, p);
    end
    r.ok = (st == ST_OK);
    r.block_page = blk[PAGE_W-1:0];
    r.status = st;
    r.free_count = pages_free;
    return r;
  endfunction

  function automatic in_word_t pick_word();
    in_word_t w;
    block_t b;
    block_t keep;
    int idx;
    int sel;
    w.action = ACT_ALLOC;
    w.page = PAGE_W'($urandom);
    w.dma = $urandom_range(0, 2) == 0;
    w.order = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 3) : $urandom_range(0, 9);
    sel = $urandom_range(0, 99);
    if (sel < 12) begin
      w.action = $urandom_range(0, 1);
      if (limit_pages < NUM_PAGES && $urandom_range(0, 1) == 1) begin
        w.action = ACT_FREE;
        w.page = $urandom_range(limit_pages, NUM_PAGES - 1);
      end else begin
        w.order = $urandom_range(ORDERS, 15);
      end
    end else if (sel < 55 && held_blocks.size() > 0) begin
      idx = $urandom_range(0, held_blocks.size() - 1);
      b = held_blocks[idx];
      held_blocks.delete(idx);
      if (b.ord > 0 && $urandom_range(0, 3) == 0) begin
        b.ord--;
        keep = b;
        if ($urandom_range(0, 1) == 1) b.pg += 1 << b.ord;
        else keep.pg += 1 << b.ord;
        held_blocks.push_back(keep);
      end
      w.action = ACT_FREE;
      w.order = b.ord;
      w.dma = b.pool;
      w.page = b.pg + $urandom_range(0, (1 << b.ord) - 1);
    end
    return w;
  endfunction

  task automatic send_word(in_word_t w, bit chk, out_word_t e, bit last_in_burst, int gap);
    out_word_t r;
    block_t b;
    int pool_used;
    b.pg = 0;
    in_valid <= 1'b1;
    in_word <= w;
    do @(posedge clk); while (in_stall);
    r = allocator_step(w, pool_used);
    pending_results.push_back(chk ? e : r);
    if (w.action == ACT_ALLOC && r.ok) begin
      b.pg = r.block_page;
      b.ord = w.order;
      b.pool = pool_used;
      held_blocks.push_back(b);
    end
    if (last_in_burst && gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() > 0) @(posedge clk);
  endtask

  task automatic write_limit(int v);
    drain();
    repeat (64) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= CNT_W'(v);
    @(posedge clk);
    cfg_we <= 1'b0;
    limit_pages = CNT_W'(v);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      stall_cnt <= stall_cnt + 1;
      if (stall_cnt % 300 == 0) stall_mode <= $urandom_range(0, 3);
      case (stall_mode)
        0: begin
          out_stall <= 1'b0;
        end
        1: begin
          out_stall <= $urandom_range(0, 3) == 0;
        end
        2: begin
          out_stall <= $urandom_range(0, 3) != 0;
        end
        default: begin
          out_stall <= (stall_cnt % 7) < 3;
        end
      endcase
    end
  end

  always @(posedge clk) begin
    out_word_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected output word %p", out_word);
      end else begin
        e = pending_results.pop_front();
        if (out_word.ok !== e.ok || out_word.block_page !== e.block_page ||
            out_word.status !== e.status || out_word.free_count !== e.free_count) begin
          mismatches++;
          if (mismatches <= 10) $display("Mismatch: expected %p, got %p", e, out_word);
        end
      end
    end
  end

  initial begin
    #20_000_000;
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    int limits [5];
    int burst;
    int gap;
    int n;
    block_t b;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_word <= '0;
    cfg_we <= 1'b0;
    cfg_wdata <= '0;
    limits = '{8191, 0, 2048, 4096, 3000};
    foreach (next_pg[i]) begin
      next_pg[i] = 0;
      prev_pg[i] = 0;
    end
    foreach (pair_bits[i]) pair_bits[i] = 1'b0;
    foreach (head_pg[i]) begin
      head_pg[i] = NIL;
      list_len[i] = '0;
    end
    pages_free = '0;
    limit_pages = CNT_W'(NUM_PAGES);
    for (int i = 0; i < 8; i++) begin
      b.pg = i * 512;
      b.ord = 9;
      b.pool = (i < 2);
      if (b.pg != 1024) held_blocks.push_back(b);
    end
    directed_rows = '{
      '{'{ACT_ALLOC, 12'd0, 4'd0, 1'b0}, 1, '{1'b0, 12'd0, ST_NOMEM, 13'd0}},
      '{'{ACT_ALLOC, 12'd4095, 4'd9, 1'b1}, 1, '{1'b0, 12'd0, ST_NOMEM, 13'd0}},
      '{'{ACT_ALLOC, 12'd0, 4'd15, 1'b0}, 1, '{1'b0, 12'd0, ST_ORDER, 13'd0}},
      '{'{ACT_FREE, 12'd0, 4'd10, 1'b0}, 1, '{1'b0, 12'd0, ST_ORDER, 13'd0}},
      '{'{ACT_FREE, 12'd4095, 4'd15, 1'b1}, 1, '{1'b0, 12'd0, ST_ORDER, 13'd0}},
      '{'{ACT_FREE, 12'd1061, 4'd9, 1'b0}, 1, '{1'b1, 12'd0, ST_OK, 13'd512}},
      '{'{ACT_ALLOC, 12'd0, 4'd0, 1'b0}, 0, '0},
      '{'{ACT_ALLOC, 12'd0, 4'd9, 1'b0}, 0, '0},
      '{'{ACT_ALLOC, 12'd0, 4'd0, 1'b1}, 0, '0},
      '{'{ACT_ALLOC, 12'd0, 4'd3, 1'b0}, 0, '0},
      '{'{ACT_ALLOC, 12'd0, 4'd8, 1'b0}, 0, '0}
    };
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    foreach (directed_rows[i])
      send_word(directed_rows[i].w, directed_rows[i].chk, directed_rows[i].e, 1,
                $urandom_range(0, 3));
    foreach (limits[ph]) begin
      write_limit(limits[ph]);
      n = 0;
      while (n < 280) begin
        burst = $urandom_range(1, 16);
        gap = (ph == 3) ? 0 : $urandom_range(0, 12);
        for (int k = 0; k < burst; k++) begin
          send_word(pick_word(), 0, '0, k == burst - 1, gap);
          n++;
          if (ph == 2 && n == 140) drain();
        end
      end
    end
    drain();
    repeat (100) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
